/* rtl/frl_pkg.sv */
// shared types, widths and constants of the frame bandwidth rate limiter
// no dependencies
package frl_pkg;

    localparam int WINDOW_SLOTS = 8;

    localparam int SIZE_W    = 16;
    localparam int RATE_W    = 20;
    localparam int FDIV_W    = 5;
    localparam int TIME_W    = 32;
    localparam int TOTAL_W   = 24;
    localparam int DELAY_W   = 26;
    localparam int COUNT_W   = 32;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = RATE_W;

    localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int SUM_W   = $clog2(WINDOW_SLOTS * ((1 << SIZE_W) - 1) + 1);
    localparam int PROD_W  = SUM_W + FDIV_W;
    localparam int MS_W    = 10;
    localparam int SCALE_W = SIZE_W + MS_W;
    localparam int DIVIDEND_W = (PROD_W > SCALE_W) ? PROD_W : SCALE_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [MS_W-1:0]    MS_PER_SECOND = MS_W'(1000);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_FRAME_DIV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_FRAME_DIV = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME_CHECK  = 2'd0,
        CMD_RECORD_SEND  = 2'd1,
        CMD_ADVANCE      = 2'd2,
        CMD_PACING_QUERY = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [RATE_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              write;
        logic              advance;
        logic [SIZE_W-1:0] value;
    } ring_ctl_t;

endpackage

/* rtl/frl_item_if.sv */
// input and result channel interfaces of the frame bandwidth rate limiter
// depends on frl_pkg
interface frl_item_if;
    logic                           valid;
    logic                           ready;
    logic [frl_pkg::CMD_W-1:0]      cmd;
    logic [frl_pkg::SIZE_W-1:0]     packet_size;
    logic                           spawned;
    logic [frl_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, cmd, packet_size, spawned, now_ms, input ready);
    modport sink   (input valid, cmd, packet_size, spawned, now_ms, output ready);
endinterface

interface frl_result_if;
    logic                           valid;
    logic                           ready;
    logic                           suppressed;
    logic                           may_send;
    logic [frl_pkg::TOTAL_W-1:0]    window_total;
    logic [frl_pkg::DELAY_W-1:0]    pacing_delta;
    logic [frl_pkg::COUNT_W-1:0]    suppress_total;

    modport source (output valid, suppressed, may_send, window_total, pacing_delta,
                    suppress_total, input ready);
    modport sink   (input valid, suppressed, may_send, window_total, pacing_delta,
                    suppress_total, output ready);
endinterface

/* rtl/frame_bandwidth_rate_limiter.sv */
// frame bandwidth rate limiter: sequencer, config registers and result register
// depends on frl_pkg, frl_item_if, frl_result_if, frl_div and frl_ring
//
// usage
//   item channel carries one command word: frame check, record send, advance
//   slot or pacing query, with packet size, spawned flag and time in ms
//   result channel returns one word per command: suppressed flag, may_send
//   flag, scaled window total, pacing delta and suppress count
//   cfg_we / cfg_index / cfg_data write rate_limit, server and client frame
//   divisors; write only while the block is idle
// timing
//   one word is worked on at a time; item.ready is high only in the idle state
//   every command runs one scaling division on the shared bit-serial divider;
//   the next word is taken once its result has moved into the output register
//   a record send with a non-zero rate also divides size*1000 by the rate on
//   the same divider first
// reset
//   ring, running sum, slot pointer, last send time, delay and suppress count clear;
//   rate_limit resets to 0 (unlimited), both frame divisors to 1
// stalls
//   the result sits in an output register; a new word is accepted while it
//   waits, and the next result holds in the done state until the register frees
module frame_bandwidth_rate_limiter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [frl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frl_pkg::CFG_W-1:0]       cfg_data,
    frl_item_if.sink                        item,
    frl_result_if.source                    result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DLY,
        S_TOT,
        S_TOT_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [frl_pkg::RATE_W-1:0] rate_reg;
    logic [frl_pkg::FDIV_W-1:0] sdiv_reg;
    logic [frl_pkg::FDIV_W-1:0] cdiv_reg;

    // latched command word
    frl_pkg::cmd_t              cmd_reg;
    logic [frl_pkg::SIZE_W-1:0] size_reg;
    logic                       spawned_reg;
    logic [frl_pkg::TIME_W-1:0] now_reg;

    // limiter state
    logic [frl_pkg::TIME_W-1:0]  last_reg;
    logic [frl_pkg::DELAY_W-1:0] delay_reg;
    logic [frl_pkg::COUNT_W-1:0] cnt_reg;

    // result register
    logic                        out_valid_reg;
    logic                        supp_reg;
    logic                        may_reg;
    logic [frl_pkg::TOTAL_W-1:0] total_reg;
    logic                        out_supp_reg;
    logic                        out_may_reg;
    logic [frl_pkg::TOTAL_W-1:0] out_total_reg;
    logic [frl_pkg::DELAY_W-1:0] out_delay_reg;
    logic [frl_pkg::COUNT_W-1:0] out_cnt_reg;

    frl_pkg::div_req_t  div_req;
    frl_pkg::div_rsp_t  div_rsp;
    frl_pkg::ring_ctl_t ring_ctl;
    logic [frl_pkg::SUM_W-1:0] ring_sum;

    logic                        rate_on;
    logic                        record_div;
    logic [frl_pkg::TOTAL_W-1:0] total_sat;
    logic                        suppress_hit;
    logic [frl_pkg::FDIV_W-1:0]  den;

    frl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    frl_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .sum   (ring_sum)
    );

    assign rate_on    = (rate_reg != '0);
    assign record_div = (state_reg == S_EXEC) && (cmd_reg == frl_pkg::CMD_RECORD_SEND) && rate_on;
    assign den        = (cdiv_reg == '0) ? frl_pkg::FDIV_W'(1) : cdiv_reg;

    // scaled total saturates before the rate compare
    assign total_sat = (div_rsp.quotient > frl_pkg::DIVIDEND_W'(frl_pkg::TOTAL_MAX))
                     ? frl_pkg::TOTAL_MAX : div_rsp.quotient[frl_pkg::TOTAL_W-1:0];
    assign suppress_hit = (cmd_reg == frl_pkg::CMD_FRAME_CHECK) && rate_on
                        && (total_sat > frl_pkg::TOTAL_W'(rate_reg));

    // divider feed: pacing delay on a record send, then the window scaling
    always_comb
    begin
        div_req.start = record_div || (state_reg == S_TOT);
        if (state_reg == S_EXEC)
        begin
            div_req.dividend = frl_pkg::DIVIDEND_W'(size_reg)
                             * frl_pkg::DIVIDEND_W'(frl_pkg::MS_PER_SECOND);
            div_req.divisor  = rate_reg;
        end
        else
        begin
            div_req.dividend = frl_pkg::DIVIDEND_W'(ring_sum)
                             * frl_pkg::DIVIDEND_W'(sdiv_reg);
            div_req.divisor  = frl_pkg::RATE_W'(den);
        end
    end

    // ring writes: recorded size for a spawned client under a non-zero rate, zero on suppression
    always_comb
    begin
        ring_ctl.write   = (record_div && spawned_reg)
                         || ((state_reg == S_TOT_WAIT) && div_rsp.done && suppress_hit);
        ring_ctl.advance = (state_reg == S_EXEC) && (cmd_reg == frl_pkg::CMD_ADVANCE);
        ring_ctl.value   = (state_reg == S_EXEC) ? size_reg : '0;
    end

    // command word capture
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            cmd_reg     <= frl_pkg::cmd_t'(item.cmd);
            size_reg    <= item.packet_size;
            spawned_reg <= item.spawned;
            now_reg     <= item.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= '0;
            sdiv_reg      <= frl_pkg::FDIV_W'(1);
            cdiv_reg      <= frl_pkg::FDIV_W'(1);
            last_reg      <= '0;
            delay_reg     <= '0;
            cnt_reg       <= '0;
            supp_reg      <= 1'b0;
            may_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_supp_reg  <= 1'b0;
            out_may_reg   <= 1'b0;
            out_total_reg <= '0;
            out_delay_reg <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    frl_pkg::REG_RATE_LIMIT:       rate_reg <= cfg_data;
                    frl_pkg::REG_SERVER_FRAME_DIV: sdiv_reg <= cfg_data[frl_pkg::FDIV_W-1:0];
                    frl_pkg::REG_CLIENT_FRAME_DIV: cdiv_reg <= cfg_data[frl_pkg::FDIV_W-1:0];
                    default:                       ;
                endcase
            end

            // in the done state the leaving word is replaced by the next one below
            if (result.valid && result.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        supp_reg  <= 1'b0;
                        may_reg   <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (cmd_reg)
                        frl_pkg::CMD_RECORD_SEND:
                        begin
                            last_reg <= now_reg;
                            if (rate_on)
                            begin
                                state_reg <= S_DLY;
                            end
                            else
                            begin
                                delay_reg <= '0;
                                state_reg <= S_TOT;
                            end
                        end
                        frl_pkg::CMD_PACING_QUERY:
                        begin
                            // wrapping elapsed time against the stored delay
                            may_reg   <= ((now_reg - last_reg) >= frl_pkg::TIME_W'(delay_reg));
                            state_reg <= S_TOT;
                        end
                        frl_pkg::CMD_FRAME_CHECK,
                        frl_pkg::CMD_ADVANCE:
                        begin
                            state_reg <= S_TOT;
                        end
                    endcase
                end
                S_DLY:
                begin
                    if (div_rsp.done)
                    begin
                        delay_reg <= div_rsp.quotient[frl_pkg::DELAY_W-1:0];
                        state_reg <= S_TOT;
                    end
                end
                S_TOT:
                begin
                    state_reg <= S_TOT_WAIT;
                end
                S_TOT_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        // total reported is the one compared, before the slot clears
                        total_reg <= total_sat;
                        if (suppress_hit)
                        begin
                            supp_reg <= 1'b1;
                            cnt_reg  <= cnt_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_supp_reg  <= supp_reg;
                        out_may_reg   <= may_reg;
                        out_total_reg <= total_reg;
                        out_delay_reg <= delay_reg;
                        out_cnt_reg   <= cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.suppressed     = out_supp_reg;
    assign result.may_send       = out_may_reg;
    assign result.window_total   = out_total_reg;
    assign result.pacing_delta   = out_delay_reg;
    assign result.suppress_total = out_cnt_reg;

`ifndef SYNTH
    // suppress count only ever steps by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("suppress count jumped");

    // the shared divider is never restarted mid-division
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a new word is only taken once the divider is idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !div_rsp.busy)
        else $error("input ready with divider busy");

    // a suppression always clears the current slot
    a_supp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_TOT_WAIT) && div_rsp.done && suppress_hit)
        |-> (ring_ctl.write && (ring_ctl.value == '0)))
        else $error("suppressed frame left slot intact");
`endif

endmodule

/* rtl/frl_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on frl_pkg
module frl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  frl_pkg::div_req_t req,
    output frl_pkg::div_rsp_t rsp
);

    logic [frl_pkg::DIVIDEND_W-1:0] quot_reg;
    logic [frl_pkg::RATE_W-1:0]     rem_reg;
    logic [frl_pkg::RATE_W-1:0]     divisor_reg;
    logic [frl_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [frl_pkg::RATE_W:0] rem_shift;
    logic [frl_pkg::RATE_W:0] rem_diff;
    logic                     fits;

    assign rem_shift = {rem_reg, quot_reg[frl_pkg::DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= frl_pkg::DIV_CNT_W'(frl_pkg::DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == frl_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out while quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[frl_pkg::DIVIDEND_W-2:0], fits};
            rem_reg  <= fits ? rem_diff[frl_pkg::RATE_W-1:0] : rem_shift[frl_pkg::RATE_W-1:0];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

/* rtl/frl_ring.sv */
// ring of recent packet sizes with running sum and slot pointer
// depends on frl_pkg
module frl_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  frl_pkg::ring_ctl_t          ctl,
    output logic [frl_pkg::SUM_W-1:0]   sum
);

    logic [frl_pkg::SIZE_W-1:0] ring_reg [frl_pkg::WINDOW_SLOTS];
    logic [frl_pkg::SUM_W-1:0]  sum_reg;
    logic [frl_pkg::SUM_W-1:0]  sum_next;
    logic [frl_pkg::SLOT_W-1:0] ptr_reg;
    logic [frl_pkg::SLOT_W-1:0] ptr_next;

    assign sum_next = sum_reg - frl_pkg::SUM_W'(ring_reg[ptr_reg])
                    + frl_pkg::SUM_W'(ctl.value);
    assign ptr_next = (ptr_reg == frl_pkg::SLOT_W'(frl_pkg::WINDOW_SLOTS - 1))
                    ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < frl_pkg::WINDOW_SLOTS; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            if (ctl.write)
            begin
                ring_reg[ptr_reg] <= ctl.value;
                sum_reg           <= sum_next;
            end
            if (ctl.advance)
            begin
                ptr_reg <= ptr_next;
            end
        end
    end

    assign sum = sum_reg;

endmodule

/* tb/sv/tb_frame_bandwidth_rate_limiter.sv */
`timescale 1ns / 1ps
// self-checking testbench for frame_bandwidth_rate_limiter: directed and random command words
// with an in-bench predictor and a scoreboard class; depends on frl_pkg, frl_item_if and
// frl_result_if

module tb_frame_bandwidth_rate_limiter;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    // a full run is 525 command words; the limit leaves a wide margin
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 64;
    localparam int PRINT_CAP       = 30;
    // index past the last register, must be ignored by the block
    localparam logic [frl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // one result word as the block should present it
    typedef struct packed {
        logic                         suppressed;
        logic                         may_send;
        logic [frl_pkg::TOTAL_W-1:0]  window_total;
        logic [frl_pkg::DELAY_W-1:0]  pacing_delta;
        logic [frl_pkg::COUNT_W-1:0]  suppress_total;
    } limiter_out_t;

    // limiter scoreboard: own copy of the window ring, timing state and registers
    class limiter_scoreboard;
        logic [frl_pkg::RATE_W-1:0]  rate;
        logic [frl_pkg::FDIV_W-1:0]  server_div;
        logic [frl_pkg::FDIV_W-1:0]  client_div;
        logic [frl_pkg::SIZE_W-1:0]  sizes [frl_pkg::WINDOW_SLOTS];
        logic [frl_pkg::SUM_W-1:0]   size_sum;
        logic [frl_pkg::SLOT_W-1:0]  slot;
        logic [frl_pkg::COUNT_W-1:0] drop_count;
        logic [frl_pkg::TIME_W-1:0]  sent_at;
        logic [frl_pkg::DELAY_W-1:0] send_gap;
        limiter_out_t                awaited [$];
        int errors;
        int words_in;
        int words_out;
        int drops_seen;
        int grants_seen;

        function new();
            rate       = '0;
            server_div = frl_pkg::FDIV_W'(1);
            client_div = frl_pkg::FDIV_W'(1);
            foreach (sizes[i])
                sizes[i] = '0;
            size_sum   = '0;
            slot       = '0;
            drop_count = '0;
            sent_at    = '0;
            send_gap   = '0;
            errors     = 0;
            words_in   = 0;
            words_out  = 0;
            drops_seen = 0;
            grants_seen = 0;
        endfunction

        function void set_reg(logic [frl_pkg::CFG_IDX_W-1:0] idx,
                              logic [frl_pkg::CFG_W-1:0] data);
            case (idx)
                frl_pkg::REG_RATE_LIMIT:       rate       = data[frl_pkg::RATE_W-1:0];
                frl_pkg::REG_SERVER_FRAME_DIV: server_div = data[frl_pkg::FDIV_W-1:0];
                frl_pkg::REG_CLIENT_FRAME_DIV: client_div = data[frl_pkg::FDIV_W-1:0];
                default: ;
            endcase
        endfunction

        // ring sum times server/client divisor ratio, client zero counts as one
        function logic [frl_pkg::TOTAL_W-1:0] window_scaled();
            logic [63:0]                prod;
            logic [frl_pkg::FDIV_W-1:0] den;
            den  = (client_div == '0) ? frl_pkg::FDIV_W'(1) : client_div;
            prod = 64'(size_sum) * 64'(server_div) / 64'(den);
            return (prod > 64'(frl_pkg::TOTAL_MAX)) ? frl_pkg::TOTAL_MAX
                                                     : prod[frl_pkg::TOTAL_W-1:0];
        endfunction

        function void fill_slot(logic [frl_pkg::SIZE_W-1:0] value);
            size_sum    = size_sum - frl_pkg::SUM_W'(sizes[slot]) + frl_pkg::SUM_W'(value);
            sizes[slot] = value;
        endfunction

        // accepted command word: advance the state and queue the result it must give
        function void note_word(frl_pkg::cmd_t cmd, logic [frl_pkg::SIZE_W-1:0] size,
                                logic spawned, logic [frl_pkg::TIME_W-1:0] now);
            limiter_out_t               o;
            logic [frl_pkg::TIME_W-1:0] elapsed;
            o = '0;
            words_in++;
            case (cmd)
                frl_pkg::CMD_FRAME_CHECK:
                begin
                    o.window_total = window_scaled();
                    if (rate != '0 && o.window_total > frl_pkg::TOTAL_W'(rate))
                    begin
                        o.suppressed = 1'b1;
                        drop_count++;
                        fill_slot('0);
                    end
                end
                frl_pkg::CMD_RECORD_SEND:
                begin
                    sent_at = now;
                    if (rate == '0)
                        send_gap = '0;
                    else
                    begin
                        if (spawned)
                            fill_slot(size);
                        send_gap = frl_pkg::DELAY_W'((64'(size) * 64'(frl_pkg::MS_PER_SECOND))
                                                     / 64'(rate));
                    end
                end
                frl_pkg::CMD_ADVANCE:
                    slot = (slot == frl_pkg::SLOT_W'(frl_pkg::WINDOW_SLOTS - 1)) ? '0
                                                                                 : slot + 1'b1;
                frl_pkg::CMD_PACING_QUERY:
                begin
                    elapsed    = now - sent_at;
                    o.may_send = (elapsed >= frl_pkg::TIME_W'(send_gap));
                end
            endcase
            if (cmd != frl_pkg::CMD_FRAME_CHECK)
                o.window_total = window_scaled();
            o.pacing_delta   = send_gap;
            o.suppress_total = drop_count;
            awaited.push_back(o);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_word(limiter_out_t got);
            limiter_out_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result word with nothing pending (total %0d)",
                                 got.window_total));
                return;
            end
            want = awaited.pop_front();
            words_out++;
            drops_seen  += want.suppressed;
            grants_seen += want.may_send;
            if (got.suppressed !== want.suppressed)
                report($sformatf("word %0d suppressed %b, want %b", words_out,
                                 got.suppressed, want.suppressed));
            if (got.may_send !== want.may_send)
                report($sformatf("word %0d may_send %b, want %b", words_out,
                                 got.may_send, want.may_send));
            if (got.window_total !== want.window_total)
                report($sformatf("word %0d window_total %0d, want %0d", words_out,
                                 got.window_total, want.window_total));
            if (got.pacing_delta !== want.pacing_delta)
                report($sformatf("word %0d pacing_delta %0d, want %0d", words_out,
                                 got.pacing_delta, want.pacing_delta));
            if (got.suppress_total !== want.suppress_total)
                report($sformatf("word %0d suppress_total %0d, want %0d", words_out,
                                 got.suppress_total, want.suppress_total));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [frl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [frl_pkg::CFG_W-1:0]     cfg_data;

    frl_item_if   item_ch ();
    frl_result_if result_ch ();

    frame_bandwidth_rate_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    limiter_scoreboard sb;

    // idling on both channels only while this is set
    bit          idle_on = 1'b0;
    int          stall_left = 0;
    int unsigned cycle_count = 0;

    always #CLK_HALF clk = ~clk;

    // result side back-pressure: ready drops for random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left       <= stall_left - 1;
            result_ch.ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left       <= $urandom_range(0, 8);
            result_ch.ready  <= 1'b0;
        end
        else
            result_ch.ready  <= 1'b1;
    end

    // result monitor and run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_word('{result_ch.suppressed, result_ch.may_send, result_ch.window_total,
                            result_ch.pacing_delta, result_ch.suppress_total});
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still pending", cycle_count,
                     sb.awaited.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one command word, optionally after a gap; returns at the accepting edge
    // with valid still high so the next word can follow back to back
    task automatic send_word(frl_pkg::cmd_t cmd, logic [frl_pkg::SIZE_W-1:0] size,
                             logic spawned, logic [frl_pkg::TIME_W-1:0] now);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= cmd;
        item_ch.packet_size <= size;
        item_ch.spawned     <= spawned;
        item_ch.now_ms      <= now;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_word(cmd, size, spawned, now);
    endtask

    // stop offering words and wait until every pending result has come out
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [frl_pkg::CFG_IDX_W-1:0] idx,
                           logic [frl_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // all three registers, then a stray write past the last index that must do nothing
    task automatic program_regs(logic [frl_pkg::CFG_W-1:0] rate_word,
                                logic [frl_pkg::CFG_W-1:0] server_word,
                                logic [frl_pkg::CFG_W-1:0] client_word);
        put_reg(frl_pkg::REG_RATE_LIMIT, rate_word);
        put_reg(frl_pkg::REG_SERVER_FRAME_DIV, server_word);
        put_reg(frl_pkg::REG_CLIENT_FRAME_DIV, client_word);
        put_reg(REG_UNUSED, frl_pkg::CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // divisor word with junk in the bits above the register width
    function automatic logic [frl_pkg::CFG_W-1:0] div_word(int unsigned div);
        return {(frl_pkg::CFG_W - frl_pkg::FDIV_W)'($urandom), frl_pkg::FDIV_W'(div)};
    endfunction

    // random command word; most are well-formed traffic around the last send,
    // the rest use arbitrary times
    task automatic random_word();
        int                         pick;
        logic [frl_pkg::SIZE_W-1:0] size;
        logic                       spawned;
        logic [frl_pkg::TIME_W-1:0] now;
        logic [frl_pkg::TIME_W-1:0] due;
        pick    = $urandom_range(0, 99);
        size    = ($urandom_range(0, 1) != 0) ? frl_pkg::SIZE_W'($urandom)
                                              : frl_pkg::SIZE_W'($urandom_range(0, 1023));
        spawned = ($urandom_range(0, 7) != 0);
        now     = sb.sent_at + frl_pkg::TIME_W'($urandom_range(0, 3000));
        if ($urandom_range(0, 4) == 0)
            now = frl_pkg::TIME_W'($urandom);
        if (pick < 30)
            send_word(frl_pkg::CMD_RECORD_SEND, size, spawned, now);
        else if (pick < 50)
            send_word(frl_pkg::CMD_ADVANCE, size, spawned, now);
        else if (pick < 75)
            send_word(frl_pkg::CMD_FRAME_CHECK, size, spawned, now);
        else
        begin
            // aim at the pacing boundary so both answers turn up
            due = sb.sent_at + frl_pkg::TIME_W'(sb.send_gap);
            if ($urandom_range(0, 2) != 0)
                now = due + frl_pkg::TIME_W'($urandom_range(0, 6)) - frl_pkg::TIME_W'(3);
            send_word(frl_pkg::CMD_PACING_QUERY, size, spawned, now);
        end
    endtask

    initial
    begin
        int unsigned rate_pick;
        int unsigned server_pick;
        int unsigned client_pick;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = frl_pkg::REG_RATE_LIMIT;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.cmd         = frl_pkg::CMD_FRAME_CHECK;
        item_ch.packet_size = '0;
        item_ch.spawned     = 1'b0;
        item_ch.now_ms      = '0;
        sb = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // reset settings, unlimited rate: record leaves the ring alone and the delay
        // at zero, the frame check never drops, time wraps on the pacing query
        send_word(frl_pkg::CMD_RECORD_SEND, '1, 1'b1, '1);
        send_word(frl_pkg::CMD_FRAME_CHECK, '0, 1'b0, '0);
        send_word(frl_pkg::CMD_PACING_QUERY, '0, 1'b0, '0);
        send_word(frl_pkg::CMD_ADVANCE, '1, 1'b1, '1);
        drain();

        // largest rate, server divisor 31, client divisor written as zero (acts as one);
        // fill every slot with the largest size so the pointer wraps, then drop a frame
        program_regs('1, div_word(31), div_word(0));
        for (int i = 0; i < frl_pkg::WINDOW_SLOTS; i++)
        begin
            send_word(frl_pkg::CMD_RECORD_SEND, '1, 1'b1, frl_pkg::TIME_W'(i));
            send_word(frl_pkg::CMD_ADVANCE, '0, 1'b0, '1);
        end
        send_word(frl_pkg::CMD_FRAME_CHECK, '0, 1'b0, '0);
        drain();

        // smallest rate, server divisor zero: total reads zero; unspawned record still
        // sets the delay, then query one ms short of it and exactly at it across the wrap
        program_regs(frl_pkg::CFG_W'(1), div_word(0), div_word(16));
        send_word(frl_pkg::CMD_FRAME_CHECK, '1, 1'b1, '1);
        send_word(frl_pkg::CMD_RECORD_SEND, frl_pkg::SIZE_W'(1), 1'b0, 32'hFFFF_FFF8);
        send_word(frl_pkg::CMD_PACING_QUERY, '0, 1'b1, 32'h0000_03DF);
        send_word(frl_pkg::CMD_PACING_QUERY, '0, 1'b1, 32'h0000_03E0);
        drain();

        // random phases, each with its own register setting; the last one runs
        // without any idling on either side
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = 1'b0;
            case (phase)
                0:       rate_pick = 0;
                1:       rate_pick = (1 << frl_pkg::RATE_W) - 1;
                default: rate_pick = ($urandom_range(0, 1) != 0)
                                   ? $urandom_range(1, 4000)
                                   : $urandom_range(1, (1 << frl_pkg::RATE_W) - 1);
            endcase
            server_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16);
            client_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16);
            if (phase == 1)
            begin
                server_pick = 31;
                client_pick = 1;
            end
            program_regs(frl_pkg::CFG_W'(rate_pick), div_word(server_pick),
                         div_word(client_pick));
            idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (WORDS_PER_PHASE) random_word();
            drain();
        end

        $display("ran %0d command words, checked %0d results over %0d register settings",
                 sb.words_in, sb.words_out, RANDOM_PHASES + 3);
        $display("saw %0d suppressed frames and %0d pacing grants, %0d mismatches",
                 sb.drops_seen, sb.grants_seen, sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
